// ===== src/vad_pkg.sv =====
// Shared types and constants for the DC-blocked voice activity detector.
// Used by vad_ctrl, vad_datapath and the top level.
package vad_pkg;

  localparam int unsigned OutLimit = 32700;
  localparam int unsigned InW      = 32;
  localparam int unsigned OutW     = 80;
  localparam int unsigned CfgW     = 15;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LEVEL   = 2'd0,
    REG_SHIFT   = 2'd1,
    REG_TRIGGER = 2'd2,
    REG_CEILING = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] level_threshold;
    logic [4:0]  input_shift;
    logic [5:0]  trigger_score;
    logic [5:0]  score_ceiling;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic sat;
    logic acc;
    logic t1;
    logic t2;
    logic t3;
    logic score;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
  } sts_t;

endpackage

// ===== src/vad_ctrl.sv =====
// Sequencing state machine for the voice activity detector.
// Depends on vad_pkg; drives vad_datapath through cmd_t.
module vad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vad_pkg::sts_t sts_i,
  output vad_pkg::cmd_t cmd_o
);
  import vad_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SAT, ST_ACC, ST_T1, ST_T2, ST_T3, ST_SCORE, ST_OUT
  } state_e;

  state_e state_q;
  logic   valid_q;
  logic   load;

  assign load        = (state_q == ST_OUT) && (!valid_q || out_ready_i);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul    = (state_q == ST_MUL);
    cmd_o.sat    = (state_q == ST_SAT);
    cmd_o.acc    = (state_q == ST_ACC);
    cmd_o.t1     = (state_q == ST_T1);
    cmd_o.t2     = (state_q == ST_T2);
    cmd_o.t3     = (state_q == ST_T3);
    cmd_o.score  = (state_q == ST_SCORE);
    cmd_o.load   = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_SAT;
        ST_SAT:   state_q <= ST_ACC;
        ST_ACC:   state_q <= sts_i.frame_end ? ST_T1 : ST_OUT;
        ST_T1:    state_q <= ST_T2;
        ST_T2:    state_q <= ST_T3;
        ST_T3:    state_q <= ST_SCORE;
        ST_SCORE: state_q <= ST_OUT;
        ST_OUT:   if (load) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/vad_datapath.sv =====
// Filter, frame statistics, speech tests and score for the detector.
// Depends on vad_pkg; sequenced by vad_ctrl.
module vad_datapath #(
  parameter int unsigned MAX_FRAME = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  vad_pkg::cfg_t             cfg_i,
  input  vad_pkg::cmd_t             cmd_i,
  output vad_pkg::sts_t             sts_o,
  input  logic [vad_pkg::InW-1:0]   raw_i,
  input  logic                      last_i,
  input  logic                      muted_i,
  input  logic                      clear_i,
  output logic [vad_pkg::OutW-1:0]  data_o,
  output logic                      last_o
);
  import vad_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned CW   = $clog2(MAX_FRAME + 1);
  localparam int unsigned SW   = $clog2(MAX_FRAME * OutLimit + 1);
  localparam int unsigned QW   = $clog2(longint'(MAX_FRAME) * 64'd1069290000 + 64'd1);
  localparam int unsigned VW   = ((33 + F) > 56 ? (33 + F) : 56) + 1;
  localparam int unsigned WW   = QW + 8;
  localparam logic [63:0] AlphaL = (64'd98 * (64'd1 << F) + 64'd50) / 64'd100;
  localparam logic [F-1:0] Alpha = AlphaL[F-1:0];
  localparam logic [VW:0] HMax  = (VW + 1)'(64'h007F_FFFF_FFFF_FFFF);
  localparam logic [VW:0] HMin  = (VW + 1)'(64'h0080_0000_0000_0000);
  localparam logic [55:0] Lim   = 56'(longint'(OutLimit) << F);
  localparam logic [CW-1:0] MaxN = CW'(MAX_FRAME);

  logic signed [31:0]  last_in_q;
  logic signed [55:0]  last_out_q;
  logic signed [31:0]  x_q;
  logic [VW-F-1:0]     hi_q;
  logic [F-1:0]        lo_q;
  logic                vneg_q;
  logic [VW-1:0]       phi_q;
  logic [F-1:0]        plo_q;
  logic [14:0]         a_q;
  logic                neg_q;
  logic signed [15:0]  smp_q;
  logic [SW-1:0]       abs_q;
  logic [QW-1:0]       sq_q;
  logic [14:0]         peak_q;
  logic [CW-1:0]       zc_q;
  logic [CW-1:0]       cnt_q;
  logic                lneg_q;
  logic                flast_q;
  logic                muted_q;
  logic                done_q;
  logic [29:0]         pp_q;
  logic [CW+14:0]      tn_q;
  logic [CW+29:0]      npp_q;
  logic                st_q;
  logic                og_q;
  logic                sub8_q;
  logic [5:0]          score_q;
  logic                cand_open_q;
  logic                cand_start_q;
  logic                trig_q;

  // front end
  logic signed [31:0]    xs;
  logic signed [32:0]    diff;
  logic signed [VW-1:0]  v;
  logic [VW-1:0]         m;
  always_comb begin
    xs   = $signed(raw_i) >>> cfg_i.input_shift;
    diff = 33'(xs) - 33'(last_in_q);
    v    = VW'(last_out_q) + (VW'(diff) <<< F);
    m    = v[VW-1] ? VW'(-v) : VW'(v);
  end

  // saturation and clamp
  logic [VW:0]        p;
  logic [55:0]        ay;
  logic signed [55:0] y;
  logic [14:0]        a;
  always_comb begin
    p = {1'b0, phi_q} + (VW + 1)'(plo_q);
    if (vneg_q) begin
      ay = (p > HMin) ? HMin[55:0] : p[55:0];
      y  = 56'(-$signed({1'b0, ay}));
    end else begin
      ay = (p > HMax) ? HMax[55:0] : p[55:0];
      y  = $signed(ay);
    end
    a = (ay > Lim) ? 15'(OutLimit) : 15'(ay >> F);
  end

  // frame tests
  logic [WW-1:0] n_w, s_w, q_w, p_w, z_w, t_w, tn_w, npp_w, nm1;
  logic qgt, c5, c6, c12, st, og;
  always_comb begin
    n_w   = WW'(cnt_q);
    s_w   = WW'(abs_q);
    q_w   = WW'(sq_q);
    p_w   = WW'(peak_q);
    z_w   = WW'(zc_q);
    t_w   = WW'(cfg_i.level_threshold);
    tn_w  = WW'(tn_q);
    npp_w = WW'(npp_q);
    nm1   = n_w - WW'(1);
    qgt   = q_w > n_w;
    c5    = qgt && (npp_w > q_w * WW'(25));
    c6    = qgt && (npp_w > q_w * WW'(36));
    c12   = qgt && (npp_w > q_w * WW'(144));
    st = !muted_q && (cnt_q > CW'(1))
         && !(s_w * WW'(5) < tn_w * WW'(7))
         && !((p_w > t_w * WW'(12)) && c5)
         && !c6
         && !(z_w * WW'(50) < nm1)
         && !(z_w * WW'(50) > nm1 * WW'(9));
    og = !muted_q && (cnt_q > CW'(1))
         && !(s_w * WW'(5) < tn_w * WW'(3))
         && !c12
         && !(z_w * WW'(100) < nm1)
         && !(z_w * WW'(25) > nm1 * WW'(8));
  end

  // score update
  logic signed [7:0] sc;
  logic [5:0]        sc_cap;
  logic              open_d;
  logic              cstart_d;
  always_comb begin
    open_d   = cand_open_q;
    cstart_d = 1'b0;
    if (st_q) begin
      if (score_q == 6'd0 && !cand_open_q) begin
        open_d   = 1'b1;
        cstart_d = 1'b1;
      end
      sc = $signed({2'b00, score_q}) + 8'sd2;
    end else begin
      sc = $signed({2'b00, score_q}) - (sub8_q ? 8'sd8 : 8'sd3);
      if (sc <= 8'sd0) begin
        sc     = 8'sd0;
        open_d = 1'b0;
      end
    end
    sc_cap = (sc > $signed({2'b00, cfg_i.score_ceiling})) ? cfg_i.score_ceiling : sc[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_in_q   <= '0;
      last_out_q  <= '0;
      abs_q       <= '0;
      sq_q        <= '0;
      peak_q      <= '0;
      zc_q        <= '0;
      cnt_q       <= '0;
      lneg_q      <= 1'b0;
      score_q     <= '0;
      cand_open_q <= 1'b0;
    end else begin
      if (cmd_i.accept && clear_i) begin
        score_q     <= '0;
        cand_open_q <= 1'b0;
      end
      if (cmd_i.sat) begin
        last_in_q  <= x_q;
        last_out_q <= y;
      end
      if (cmd_i.acc) begin
        abs_q  <= abs_q + SW'(a_q);
        sq_q   <= sq_q + QW'(a_q * a_q);
        if (a_q > peak_q) peak_q <= a_q;
        if (cnt_q != '0 && neg_q != lneg_q) zc_q <= zc_q + CW'(1);
        lneg_q <= neg_q;
        cnt_q  <= cnt_q + CW'(1);
      end
      if (cmd_i.score) begin
        score_q     <= sc_cap;
        cand_open_q <= open_d;
      end
      if (cmd_i.load && done_q) begin
        abs_q  <= '0;
        sq_q   <= '0;
        peak_q <= '0;
        zc_q   <= '0;
        cnt_q  <= '0;
        lneg_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= xs;
      hi_q    <= m[VW-1:F];
      lo_q    <= m[F-1:0];
      vneg_q  <= v[VW-1];
      flast_q <= last_i;
      muted_q <= muted_i;
    end
    if (cmd_i.mul) begin
      phi_q <= VW'(hi_q * Alpha);
      plo_q <= F'(((2 * F)'(lo_q) * (2 * F)'(Alpha)) >> F);
    end
    if (cmd_i.sat) begin
      a_q   <= a;
      neg_q <= vneg_q && (a != '0);
      smp_q <= vneg_q ? -$signed({1'b0, a}) : $signed({1'b0, a});
    end
    if (cmd_i.acc) done_q <= flast_q || (cnt_q + CW'(1) >= MaxN);
    if (cmd_i.t1) begin
      pp_q <= peak_q * peak_q;
      tn_q <= cfg_i.level_threshold * cnt_q;
    end
    if (cmd_i.t2) npp_q <= cnt_q * pp_q;
    if (cmd_i.t3) begin
      st_q   <= st;
      og_q   <= og;
      sub8_q <= (s_w > tn_w * WW'(2)) && c6;
    end
    if (cmd_i.score) begin
      cand_start_q <= cstart_d;
      trig_q       <= sc_cap >= cfg_i.trigger_score;
    end
    if (cmd_i.load) begin
      last_o <= done_q;
      if (done_q) begin
        data_o <= {3'b000, 11'(cnt_q), 25'(abs_q), peak_q, cand_start_q, score_q,
                   trig_q, og_q, st_q, smp_q};
      end else begin
        data_o <= {64'd0, smp_q};
      end
    end
  end

  // read in the accumulate step, before the count takes this sample
  assign sts_o.frame_end = flast_q || (cnt_q + CW'(1) >= MaxN);

endmodule

// ===== src/dc_block_vad_frame_detector_unit.sv =====
// Top level of the DC-blocked energy / zero-crossing voice activity detector.
// Steps: the input is accepted, scaled by the filter coefficient, saturated and
// clamped, and accumulated; on the last sample of a frame the squared-peak products
// and tests and the score update follow before the result is loaded. The next
// sample is taken once the result is in the output register, so a stalled result
// holds it back. Reset clears config to defaults and all frame state.
module dc_block_vad_frame_detector_unit #(
  parameter int unsigned MAX_FRAME = 1024,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [vad_pkg::InW-1:0]      s_axis_tdata,  // raw_word
  input  logic                         s_axis_tlast,  // frame_last
  input  logic [1:0]                   s_axis_tuser,  // muted, clear_score
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // filtered_sample, start_like, ongoing_like, triggered, score_now,
  // candidate_start, frame_peak, frame_abs_sum, frame_samples, zero pad
  output logic [vad_pkg::OutW-1:0]     m_axis_tdata,
  output logic                         m_axis_tlast,  // frame_done
  input  logic                         cfg_we_i,
  input  logic [vad_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vad_pkg::CfgW-1:0]     cfg_data_i
);
  import vad_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold <= 15'd200;
      cfg_q.input_shift     <= 5'd14;
      cfg_q.trigger_score   <= 6'd18;
      cfg_q.score_ceiling   <= 6'd30;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_LEVEL:   cfg_q.level_threshold <= cfg_data_i;
        REG_SHIFT:   cfg_q.input_shift     <= cfg_data_i[4:0];
        REG_TRIGGER: cfg_q.trigger_score   <= cfg_data_i[5:0];
        REG_CEILING: cfg_q.score_ceiling   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  vad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vad_datapath #(
    .MAX_FRAME (MAX_FRAME),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .raw_i   (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .muted_i (s_axis_tuser[0]),
    .clear_i (s_axis_tuser[1]),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd32700 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd32700))
    else $error("sample outside clamp range");

  a_mid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[79:16] == '0))
    else $error("frame fields set on mid-frame result");

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[40:26] >= (m_axis_tdata[15] ? 15'(-m_axis_tdata[15:0])
                                                : m_axis_tdata[14:0])))
    else $error("frame peak below last sample magnitude");

endmodule

// ===== verif/vad_checker.sv =====
// Checker for the voice activity detector: watches config writes and both streams,
// predicts every result and compares it field by field with what the block returns.
// Depends on vad_pkg for the config register indexes.
`timescale 1ns / 1ps
module vad_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  input  logic [1:0]                  s_axis_tuser,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [vad_pkg::OutW-1:0]    m_axis_tdata,
  input  logic                        m_axis_tlast,
  input  logic                        cfg_we_i,
  input  logic [vad_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [vad_pkg::CfgW-1:0]    cfg_data_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          frames_o,
  output int                          starts_o
);
  import vad_pkg::*;

  localparam int unsigned MaxFrame = 1024;
  localparam longint AlphaQ = (98 * 65536 + 50) / 100;
  localparam longint HpfMax = (64'sd1 <<< 55) - 1;
  localparam longint Lim = 64'sd32700 * 65536;

  typedef struct packed {
    logic [15:0] sample;
    logic        done;
    logic        st;
    logic        og;
    logic        trig;
    logic [5:0]  score;
    logic        cand;
    logic [14:0] peak;
    logic [24:0] sum;
    logic [10:0] n;
  } vad_result_t;

  cfg_t        cfg;
  longint      last_in, last_out;
  longint unsigned abs_acc, sq_acc, peak_h, zc_cnt, smp_cnt;
  logic        last_neg, cand_open;
  int          score;
  vad_result_t result_q[$];
  int          sent, got;

  assign pending_o = sent - got;

  function automatic longint alpha_scale(longint v);
    longint unsigned m, p;
    longint r;
    m = (v < 0) ? longint'(-v) : v;
    p = (m >> 16) * AlphaQ + (((m & 64'hFFFF) * AlphaQ) >> 16);
    r = p;
    if (v < 0) r = -r;
    if (r > HpfMax) r = HpfMax;
    if (r < -HpfMax - 1) r = -HpfMax - 1;
    return r;
  endfunction

  function automatic bit crest_over(longint unsigned n, longint unsigned p,
                                    longint unsigned q, longint unsigned k);
    return q > n && n * p * p > k * k * q;
  endfunction

  task automatic predict_sample(logic [31:0] raw, logic last, logic mute, logic clr);
    longint x, y, smp;
    longint unsigned a, n, s, q, p, z, t;
    bit neg, done, st, og, cand;
    vad_result_t r;
    if (clr) begin
      score = 0;
      cand_open = 0;
    end
    x = longint'($signed(raw)) >>> cfg.input_shift;
    y = alpha_scale(last_out + (x - last_in) * 65536);
    last_in = x;
    last_out = y;
    if (y > Lim) smp = 32700;
    else if (y < -Lim) smp = -32700;
    else if (y >= 0) smp = y >> 16;
    else smp = -((-y) >> 16);
    a = (smp < 0) ? -smp : smp;
    neg = smp < 0;
    abs_acc += a;
    sq_acc += a * a;
    if (a > peak_h) peak_h = a;
    if (smp_cnt > 0 && neg != last_neg) zc_cnt++;
    last_neg = neg;
    smp_cnt++;
    r = '0;
    r.sample = smp[15:0];
    done = last || smp_cnt >= MaxFrame;
    if (done) begin
      n = smp_cnt; s = abs_acc; q = sq_acc; p = peak_h; z = zc_cnt;
      t = cfg.level_threshold;
      st = !mute && n > 1;
      og = st;
      cand = 0;
      if (st) begin
        if (5 * s < 7 * t * n) st = 0;
        if (p > 12 * t && crest_over(n, p, q, 5)) st = 0;
        if (crest_over(n, p, q, 6)) st = 0;
        if (50 * z < n - 1 || 50 * z > 9 * (n - 1)) st = 0;
      end
      if (og) begin
        if (5 * s < 3 * t * n) og = 0;
        if (crest_over(n, p, q, 12)) og = 0;
        if (100 * z < n - 1 || 25 * z > 8 * (n - 1)) og = 0;
      end
      if (st) begin
        if (score == 0 && !cand_open) begin
          cand_open = 1;
          cand = 1;
        end
        score += 2;
        starts_o++;
      end else begin
        if (s > 2 * t * n && crest_over(n, p, q, 6)) score -= 8;
        else score -= 3;
        if (score <= 0) begin
          score = 0;
          cand_open = 0;
        end
      end
      if (score > int'(cfg.score_ceiling)) score = cfg.score_ceiling;
      r.done = 1;
      r.st = st;
      r.og = og;
      r.trig = score >= int'(cfg.trigger_score);
      r.score = score[5:0];
      r.cand = cand;
      r.peak = p[14:0];
      r.sum = s[24:0];
      r.n = n[10:0];
      abs_acc = 0; sq_acc = 0; peak_h = 0; zc_cnt = 0; smp_cnt = 0; last_neg = 0;
      frames_o++;
    end
    result_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vad_result_t e, act;
    if (!rst_ni) begin
      cfg.level_threshold = 200;
      cfg.input_shift = 14;
      cfg.trigger_score = 18;
      cfg.score_ceiling = 30;
      last_in = 0; last_out = 0;
      abs_acc = 0; sq_acc = 0; peak_h = 0; zc_cnt = 0; smp_cnt = 0;
      last_neg = 0; cand_open = 0; score = 0;
      result_q.delete();
      sent = 0; got = 0; errors_o = 0; frames_o = 0; starts_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_LEVEL:   cfg.level_threshold = cfg_data_i[14:0];
          REG_SHIFT:   cfg.input_shift = cfg_data_i[4:0];
          REG_TRIGGER: cfg.trigger_score = cfg_data_i[5:0];
          REG_CEILING: cfg.score_ceiling = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act = '0;
        act.sample = m_axis_tdata[15:0];
        act.done = m_axis_tlast;
        act.st = m_axis_tdata[16];
        act.og = m_axis_tdata[17];
        act.trig = m_axis_tdata[18];
        act.score = m_axis_tdata[24:19];
        act.cand = m_axis_tdata[25];
        act.peak = m_axis_tdata[40:26];
        act.sum = m_axis_tdata[65:41];
        act.n = m_axis_tdata[76:66];
        got++;
        if (result_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected transaction: %h", m_axis_tdata);
        end else begin
          e = result_q.pop_front();
          if (e != act) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: exp smp=%0d done=%b st=%b og=%b trg=%b sc=%0d cd=%b pk=%0d sum=%0d n=%0d | got smp=%0d done=%b st=%b og=%b trg=%b sc=%0d cd=%b pk=%0d sum=%0d n=%0d",
                       $signed(e.sample), e.done, e.st, e.og, e.trig, e.score, e.cand,
                       e.peak, e.sum, e.n, $signed(act.sample), act.done, act.st,
                       act.og, act.trig, act.score, act.cand, act.peak, act.sum, act.n);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sent++;
        predict_sample(s_axis_tdata, s_axis_tlast, s_axis_tuser[0], s_axis_tuser[1]);
      end
    end
  end
endmodule

// ===== verif/dc_block_vad_frame_detector_unit_tb.sv =====
// Testbench top for dc_block_vad_frame_detector_unit: drives speech-like, noise and
// overrun frames under several register settings; vad_checker predicts and compares.
// Depends on vad_pkg, the block and vad_checker.
`timescale 1ns / 1ps
module dc_block_vad_frame_detector_unit_tb;
  import vad_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic s_valid = 0, s_ready, s_last = 0, m_valid, m_ready = 0, m_last, cfg_we = 0;
  logic [31:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic [OutW-1:0] m_data;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int errors, pending, frames, starts, items, burst;
  int stall_mode = 0;

  dc_block_vad_frame_detector_unit uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tlast(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  vad_checker chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .s_axis_tlast(s_last), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data),
    .m_axis_tlast(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .frames_o(frames), .starts_o(starts)
  );

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= 1'($urandom_range(0, 1));
      2: m_ready <= ($urandom_range(0, 7) == 0);
      default: m_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task automatic send(logic [31:0] raw, logic last, logic mute, logic clr);
    if (burst == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst = $urandom_range(1, 20);
    end
    burst--;
    s_valid <= 1'b1;
    s_data <= raw;
    s_last <= last;
    s_user <= {clr, mute};
    do @(posedge clk_i); while (!s_ready);
    items++;
  endtask

  task automatic drain;
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cfg(int lvl, int sh, int trg, int ceil);
    cfg_idx_e idx;
    drain();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        REG_LEVEL:   cfg_data <= CfgW'(lvl);
        REG_SHIFT:   cfg_data <= CfgW'(sh);
        REG_TRIGGER: cfg_data <= CfgW'(trg);
        default:     cfg_data <= CfgW'(ceil);
      endcase
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // square wave with random half period, shifted up by the input shift (at most 16)
  task automatic speech_frame(int len, int sh, logic mute);
    int amp, half;
    logic [31:0] raw;
    amp = $urandom_range(300, 20000);
    half = $urandom_range(3, 25);
    for (int i = 0; i < len; i++) begin
      raw = ((i / half) % 2) ? -(amp + $urandom_range(0, 200)) : amp + $urandom_range(0, 200);
      raw = raw << ((sh > 16) ? 16 : sh);
      send(raw, i == len - 1, mute, $urandom_range(0, 99) == 0);
    end
  endtask

  task automatic noise_frame(int len);
    for (int i = 0; i < len; i++)
      send($urandom, i == len - 1, 1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
  endtask

  initial begin
    int sh;
    items = 0; burst = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, single-sample frame, clear, mute
    send(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    send(32'h8000_0000, 1'b0, 1'b0, 1'b1);
    send(32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
    send(32'h0, 1'b1, 1'b0, 1'b1);
    write_cfg(0, 0, 0, 0);
    send(32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
    send(32'h8000_0000, 1'b0, 1'b0, 1'b0);
    send(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    write_cfg(32767, 31, 63, 63);
    send(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    send(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
    send(32'h8000_0000, 1'b1, 1'b0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin sh = 14; write_cfg(200, 14, 18, 30); end
        1: begin sh = 0; write_cfg(100, 0, 4, 10); end
        2: begin sh = 16; write_cfg(32767, 16, 63, 63); end
        3: begin sh = 31; write_cfg(0, 31, 0, 0); end
        default: begin
          sh = $urandom_range(0, 20);
          write_cfg($urandom_range(20, 600), sh, $urandom_range(0, 20), $urandom_range(5, 63));
        end
      endcase
      for (int f = 0; f < 8; f++) begin
        if ($urandom_range(0, 3) != 0) speech_frame($urandom_range(10, 30), sh,
                                                    $urandom_range(0, 9) == 0);
        else noise_frame($urandom_range(1, 8));
      end
      if (ph == 2) drain();
    end
    // frame overrun: no frame_last for more than MAX_FRAME samples
    for (int i = 0; i < 1030; i++) send($urandom_range(0, 1) ? 32'h0010_0000 : 32'hFFF0_0000,
                                        1'b0, 1'b0, 1'b0);
    send(32'h0, 1'b1, 1'b0, 1'b0);

    drain();
    $display("Covered %0d samples, %0d frames, %0d start-like frames over six settings.",
             items, frames, starts);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
